FILE: rtl/core/bcd_pkg.sv
package bcd_pkg;

    // Buttons handled by the block; samples for higher indexes are ignored.
    localparam int unsigned NUM_BUTTONS = 4;

    localparam int unsigned IDX_W     = 2;
    localparam int unsigned MEM_DEPTH = 2 ** IDX_W;
    localparam int unsigned CFG_IDX_W = 2;
    localparam int unsigned CFG_DATA_W = 16;
    localparam int unsigned FIRED_W   = 7;

    localparam logic [15:0] TICK_MAX   = 16'hFFFF;
    localparam logic [7:0]  DEB_MAX    = 8'hFF;
    localparam logic [3:0]  REPEAT_MAX = 4'd15;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DEBOUNCE = 2'd0,
        CFG_SHORT    = 2'd1,
        CFG_LONG     = 2'd2,
        CFG_ACTIVE   = 2'd3
    } t_cfg_idx;

    typedef enum logic [2:0] {
        PH_IDLE      = 3'd0,
        PH_PRESSED   = 3'd1,
        PH_RELEASED  = 3'd2,
        PH_REPEAT    = 3'd3,
        PH_LONG_HOLD = 3'd5
    } t_phase;

    typedef enum logic [2:0] {
        EV_NONE   = 3'd0,
        EV_DOWN   = 3'd1,
        EV_UP     = 3'd2,
        EV_SINGLE = 3'd3,
        EV_DOUBLE = 3'd4,
        EV_LSTART = 3'd5,
        EV_LHOLD  = 3'd6
    } t_event;

    // Bit positions in the fired mask.
    localparam int unsigned F_DOWN   = 0;
    localparam int unsigned F_UP     = 1;
    localparam int unsigned F_REPEAT = 2;
    localparam int unsigned F_SINGLE = 3;
    localparam int unsigned F_DOUBLE = 4;
    localparam int unsigned F_LSTART = 5;
    localparam int unsigned F_LHOLD  = 6;

    typedef struct packed {
        logic [7:0]  deb_limit;
        logic [15:0] short_limit;
        logic [15:0] long_limit;
        logic [3:0]  active_level_mask;
    } t_cfg;

    typedef struct packed {
        t_phase      phase;
        logic [15:0] tick;
        logic [7:0]  deb;
        logic        filt;
        logic [3:0]  repeats;
        t_event      last;
    } t_btn_state;

    // Reset mask is all zero, so every button starts at the inactive level one.
    localparam t_btn_state STATE_RESET = '{
        phase:   PH_IDLE,
        tick:    16'd0,
        deb:     8'd0,
        filt:    1'b1,
        repeats: 4'd0,
        last:    EV_NONE
    };

endpackage

FILE: rtl/core/bcd_cfg_regs.sv
module bcd_cfg_regs (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_wr_en,
    input  logic [bcd_pkg::CFG_IDX_W-1:0]    i_wr_idx,
    input  logic [bcd_pkg::CFG_DATA_W-1:0]   i_wr_data,
    output bcd_pkg::t_cfg                    o_cfg
);

    bcd_pkg::t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.deb_limit         <= 8'd3;
            r_cfg.short_limit       <= 16'd60;
            r_cfg.long_limit        <= 16'd200;
            r_cfg.active_level_mask <= 4'd0;
        end else if (i_wr_en) begin
            case (bcd_pkg::t_cfg_idx'(i_wr_idx))
                bcd_pkg::CFG_DEBOUNCE: r_cfg.deb_limit         <= i_wr_data[7:0];
                bcd_pkg::CFG_SHORT:    r_cfg.short_limit       <= i_wr_data[15:0];
                bcd_pkg::CFG_LONG:     r_cfg.long_limit        <= i_wr_data[15:0];
                bcd_pkg::CFG_ACTIVE:   r_cfg.active_level_mask <= i_wr_data[3:0];
                default: begin
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

FILE: rtl/core/bcd_state_mem.sv
module bcd_state_mem (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_rd_en,
    input  logic [bcd_pkg::IDX_W-1:0]    i_rd_addr,
    input  logic                         i_wr_en,
    input  logic [bcd_pkg::IDX_W-1:0]    i_wr_addr,
    input  bcd_pkg::t_btn_state          i_wr_data,
    output bcd_pkg::t_btn_state          o_rd_data
);

    bcd_pkg::t_btn_state mem [bcd_pkg::MEM_DEPTH];

    logic [bcd_pkg::MEM_DEPTH-1:0] r_vld;
    bcd_pkg::t_btn_state           r_rd_data;
    logic                          r_rd_vld;
    logic                          r_fwd_hit;
    bcd_pkg::t_btn_state           r_fwd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data  <= mem[i_rd_addr];
            r_fwd_data <= i_wr_data;
        end
    end

    // Entries never written read as their reset value.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld     <= '0;
            r_rd_vld  <= 1'b0;
            r_fwd_hit <= 1'b0;
        end else begin
            if (i_wr_en) begin
                r_vld[i_wr_addr] <= 1'b1;
            end
            if (i_rd_en) begin
                r_rd_vld  <= r_vld[i_rd_addr];
                r_fwd_hit <= i_wr_en && (i_wr_addr == i_rd_addr);
            end
        end
    end

    always_comb begin
        if (r_fwd_hit) begin
            o_rd_data = r_fwd_data;
        end else if (r_rd_vld) begin
            o_rd_data = r_rd_data;
        end else begin
            o_rd_data = bcd_pkg::STATE_RESET;
        end
    end

endmodule

FILE: rtl/core/bcd_press_fsm.sv
module bcd_press_fsm (
    input  bcd_pkg::t_btn_state              i_state,
    input  logic                             i_pin,
    input  logic                             i_act,
    input  bcd_pkg::t_cfg                    i_cfg,
    output bcd_pkg::t_btn_state              o_state,
    output logic [bcd_pkg::FIRED_W-1:0]      o_fired
);

    logic [15:0]     tick_inc;
    logic [7:0]      deb_inc;
    logic [7:0]      deb_new;
    logic            filt_new;
    logic            pressed;
    bcd_pkg::t_phase n_phase;
    logic [15:0]     n_tick;
    logic [3:0]      n_repeats;
    bcd_pkg::t_event n_last;
    logic [bcd_pkg::FIRED_W-1:0] n_fired;

    // Tick counting and debounce filter.
    always_comb begin
        tick_inc = i_state.tick;
        if (i_state.phase != bcd_pkg::PH_IDLE && i_state.tick != bcd_pkg::TICK_MAX) begin
            tick_inc = i_state.tick + 16'd1;
        end
        deb_inc  = (i_state.deb != bcd_pkg::DEB_MAX) ? i_state.deb + 8'd1 : i_state.deb;
        filt_new = i_state.filt;
        deb_new  = 8'd0;
        if (i_pin != i_state.filt) begin
            if (deb_inc >= i_cfg.deb_limit) begin
                filt_new = i_pin;
            end else begin
                deb_new = deb_inc;
            end
        end
        pressed = (filt_new == i_act);
    end

    // Next phase.
    always_comb begin
        n_phase = i_state.phase;
        case (i_state.phase)
            bcd_pkg::PH_IDLE: begin
                if (pressed) n_phase = bcd_pkg::PH_PRESSED;
            end
            bcd_pkg::PH_PRESSED: begin
                if (!pressed) begin
                    n_phase = bcd_pkg::PH_RELEASED;
                end else if (tick_inc > i_cfg.long_limit) begin
                    n_phase = bcd_pkg::PH_LONG_HOLD;
                end
            end
            bcd_pkg::PH_RELEASED: begin
                if (pressed) begin
                    n_phase = bcd_pkg::PH_REPEAT;
                end else if (tick_inc > i_cfg.short_limit) begin
                    n_phase = bcd_pkg::PH_IDLE;
                end
            end
            bcd_pkg::PH_REPEAT: begin
                if (!pressed) begin
                    n_phase = (tick_inc < i_cfg.short_limit) ? bcd_pkg::PH_RELEASED
                                                             : bcd_pkg::PH_IDLE;
                end else if (tick_inc > i_cfg.short_limit) begin
                    n_phase = bcd_pkg::PH_IDLE;
                end
            end
            bcd_pkg::PH_LONG_HOLD: begin
                if (!pressed) n_phase = bcd_pkg::PH_IDLE;
            end
            default: n_phase = bcd_pkg::PH_IDLE;
        endcase
    end

    // Events, tick restarts and repeat counting.
    always_comb begin
        n_tick    = tick_inc;
        n_repeats = i_state.repeats;
        n_last    = i_state.last;
        n_fired   = '0;
        case (i_state.phase)
            bcd_pkg::PH_IDLE: begin
                if (pressed) begin
                    n_last                   = bcd_pkg::EV_DOWN;
                    n_fired[bcd_pkg::F_DOWN] = 1'b1;
                    n_tick                   = 16'd0;
                    n_repeats                = 4'd1;
                end else begin
                    n_last = bcd_pkg::EV_NONE;
                end
            end
            bcd_pkg::PH_PRESSED: begin
                if (!pressed) begin
                    n_last                 = bcd_pkg::EV_UP;
                    n_fired[bcd_pkg::F_UP] = 1'b1;
                    n_tick                 = 16'd0;
                end else if (tick_inc > i_cfg.long_limit) begin
                    n_last                     = bcd_pkg::EV_LSTART;
                    n_fired[bcd_pkg::F_LSTART] = 1'b1;
                end
            end
            bcd_pkg::PH_RELEASED: begin
                if (pressed) begin
                    n_last                     = bcd_pkg::EV_DOWN;
                    n_fired[bcd_pkg::F_DOWN]   = 1'b1;
                    n_fired[bcd_pkg::F_REPEAT] = 1'b1;
                    if (i_state.repeats < bcd_pkg::REPEAT_MAX) begin
                        n_repeats = i_state.repeats + 4'd1;
                    end
                    n_tick = 16'd0;
                end else if (tick_inc > i_cfg.short_limit) begin
                    if (i_state.repeats == 4'd1) begin
                        n_last                     = bcd_pkg::EV_SINGLE;
                        n_fired[bcd_pkg::F_SINGLE] = 1'b1;
                    end else if (i_state.repeats == 4'd2) begin
                        n_last                     = bcd_pkg::EV_DOUBLE;
                        n_fired[bcd_pkg::F_DOUBLE] = 1'b1;
                    end
                end
            end
            bcd_pkg::PH_REPEAT: begin
                if (!pressed) begin
                    n_last                 = bcd_pkg::EV_UP;
                    n_fired[bcd_pkg::F_UP] = 1'b1;
                    if (tick_inc < i_cfg.short_limit) begin
                        n_tick = 16'd0;
                    end
                end
            end
            bcd_pkg::PH_LONG_HOLD: begin
                if (pressed) begin
                    n_last                    = bcd_pkg::EV_LHOLD;
                    n_fired[bcd_pkg::F_LHOLD] = 1'b1;
                end else begin
                    n_last                 = bcd_pkg::EV_UP;
                    n_fired[bcd_pkg::F_UP] = 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        o_state.phase   = n_phase;
        o_state.tick    = n_tick;
        o_state.deb     = deb_new;
        o_state.filt    = filt_new;
        o_state.repeats = n_repeats;
        o_state.last    = n_last;
    end

    assign o_fired = n_fired;

endmodule

FILE: rtl/core/button_click_detector.sv
// Debounce and click detector for up to four buttons that share one sample
// stream. Each input item is one tick sample of one button's raw pin, and each
// item gives exactly one result item: the button's sticky last event, a mask of
// the events that fired on this tick, the press count of the current click
// sequence and the filtered level. The per-button state lives in a small
// synchronous state memory: the address is read when an item is accepted, the
// next state is computed in stage one and written back when the item moves on,
// and a bypass register forwards that write when the following item targets
// the same button. The block takes one item per cycle while the output side
// keeps up; a result passes from stage one into the output register, and only a
// result that waits untaken in the output register holds up the input side.
// Entries carry a valid bit each, so after reset there is no clearing pass and
// items are accepted at once. Configuration writes are taken in any cycle and
// are meant to be issued only while no items are in flight.
module button_click_detector (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // Sample input channel.
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic [1:0]                        i_button_index,
    input  logic                              i_pin_sample,
    // Result output channel.
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic [1:0]                        o_button_index_out,
    output logic [2:0]                        o_event_code,
    output logic [6:0]                        o_fired_mask,
    output logic [3:0]                        o_repeat_count,
    output logic                              o_debounced_level,
    // Configuration write channel.
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [bcd_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [bcd_pkg::CFG_DATA_W-1:0]    i_cfg_data
);

    bcd_pkg::t_cfg       cfg;
    bcd_pkg::t_btn_state rd_state;
    bcd_pkg::t_btn_state upd_state;
    logic [bcd_pkg::FIRED_W-1:0] upd_fired;

    logic in_acc;
    logic s1_adv;
    logic s1_in_range;
    logic s1_act;

    // Stage one holds the item whose state is coming out of the memory.
    logic                      r_s1_vld;
    logic [bcd_pkg::IDX_W-1:0] r_s1_idx;
    logic                      r_s1_pin;

    // Output register.
    logic       r_out_vld;
    logic [1:0] r_out_idx;
    logic [2:0] r_out_event;
    logic [6:0] r_out_fired;
    logic [3:0] r_out_repeats;
    logic       r_out_level;

    assign o_cfg_ready = 1'b1;

    bcd_cfg_regs u_cfg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_en   (i_cfg_valid),
        .i_wr_idx  (i_cfg_index),
        .i_wr_data (i_cfg_data),
        .o_cfg     (cfg)
    );

    // Stage one moves on whenever the output register is free or being emptied.
    assign s1_adv     = r_s1_vld && (!r_out_vld || i_out_ready);
    assign o_in_ready = !r_s1_vld || s1_adv;
    assign in_acc     = i_in_valid && o_in_ready;

    // Samples of buttons past NUM_BUTTONS touch no state and report no event.
    assign s1_in_range = (32'(r_s1_idx) < bcd_pkg::NUM_BUTTONS);
    assign s1_act      = cfg.active_level_mask[r_s1_idx];

    bcd_state_mem u_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (in_acc),
        .i_rd_addr (i_button_index),
        .i_wr_en   (s1_adv && s1_in_range),
        .i_wr_addr (r_s1_idx),
        .i_wr_data (upd_state),
        .o_rd_data (rd_state)
    );

    bcd_press_fsm u_fsm (
        .i_state (rd_state),
        .i_pin   (r_s1_pin),
        .i_act   (s1_act),
        .i_cfg   (cfg),
        .o_state (upd_state),
        .o_fired (upd_fired)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (in_acc) begin
                r_s1_vld <= 1'b1;
            end else if (s1_adv) begin
                r_s1_vld <= 1'b0;
            end
            if (s1_adv) begin
                r_out_vld <= 1'b1;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_idx <= i_button_index;
            r_s1_pin <= i_pin_sample;
        end
        if (s1_adv) begin
            r_out_idx <= r_s1_idx;
            if (s1_in_range) begin
                r_out_event   <= upd_state.last;
                r_out_fired   <= upd_fired;
                r_out_repeats <= upd_state.repeats;
                r_out_level   <= upd_state.filt;
            end else begin
                r_out_event   <= bcd_pkg::EV_NONE;
                r_out_fired   <= '0;
                r_out_repeats <= 4'd0;
                r_out_level   <= 1'b0;
            end
        end
    end

    assign o_out_valid        = r_out_vld;
    assign o_button_index_out = r_out_idx;
    assign o_event_code       = r_out_event;
    assign o_fired_mask       = r_out_fired;
    assign o_repeat_count     = r_out_repeats;
    assign o_debounced_level  = r_out_level;

endmodule

FILE: rtl/core/bcd_checker.sv
module bcd_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_out_valid,
    input logic       i_out_ready,
    input logic [1:0] o_button_index_out,
    input logic [2:0] o_event_code,
    input logic [6:0] o_fired_mask,
    input logic [3:0] o_repeat_count,
    input logic       o_debounced_level
);

    // A result held back by the consumer stays put.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=>
            (o_out_valid && $stable(o_event_code) && $stable(o_fired_mask)
             && $stable(o_repeat_count) && $stable(o_debounced_level)
             && $stable(o_button_index_out)))
        else $error("result changed while stalled");

    // A press and a release never fire on the same tick.
    a_down_up: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_fired_mask[bcd_pkg::F_DOWN] && o_fired_mask[bcd_pkg::F_UP]))
        else $error("down and up fired together");

    // A repeat press is always also a press down, with at least two presses.
    a_repeat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_fired_mask[bcd_pkg::F_REPEAT]) |->
            (o_fired_mask[bcd_pkg::F_DOWN] && o_repeat_count >= 4'd2))
        else $error("repeat without down");

    // A fired down or up is what the sticky event code shows.
    a_event_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_fired_mask[bcd_pkg::F_DOWN] || o_fired_mask[bcd_pkg::F_UP])) |->
            (o_event_code == (o_fired_mask[bcd_pkg::F_DOWN] ? 3'(bcd_pkg::EV_DOWN)
                                                            : 3'(bcd_pkg::EV_UP))))
        else $error("event code does not match fired mask");

endmodule

bind button_click_detector bcd_checker u_bcd_checker (
    .i_clk              (i_clk),
    .i_rst_n            (i_rst_n),
    .o_out_valid        (o_out_valid),
    .i_out_ready        (i_out_ready),
    .o_button_index_out (o_button_index_out),
    .o_event_code       (o_event_code),
    .o_fired_mask       (o_fired_mask),
    .o_repeat_count     (o_repeat_count),
    .o_debounced_level  (o_debounced_level)
);

FILE: test/tb_top.sv
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    // One tick sample as it waits in the stimulus queue.
    typedef struct {
        logic [1:0] button;
        logic       pin;
    } t_tick_item;

    // What the block must report for one tick sample.
    typedef struct {
        logic [1:0]      button;
        bcd_pkg::t_event evt;
        logic [6:0]      fired;
        logic [3:0]      repeats;
        logic            level;
    } t_click_report;

    // Clock, reset and the block's input side. Everything starts at a known
    // value, and reset is held low until the main sequence releases it.
    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic [1:0] button_index = '0;
    logic       pin_sample = 1'b0;
    logic       out_ready = 1'b0;
    logic       cfg_valid = 1'b0;
    bcd_pkg::t_cfg_idx cfg_index = bcd_pkg::CFG_DEBOUNCE;
    logic [15:0] cfg_data = '0;

    logic       o_in_ready;
    logic       o_out_valid;
    logic [1:0] o_button_index_out;
    logic [2:0] o_event_code;
    logic [6:0] o_fired_mask;
    logic [3:0] o_repeat_count;
    logic       o_debounced_level;
    logic       o_cfg_ready;

    // Items still to be offered to the block, and the reports that accepted
    // items have to produce, oldest first.
    t_tick_item    tick_items_q[$];
    t_click_report click_report_q[$];

    // Percentages of cycles in which the sender idles or the receiver stalls.
    int unsigned send_idle_pct = 0;
    int unsigned recv_stall_pct = 0;
    bit          failed = 1'b0;

    // Our own copy of the configuration, updated when a write is accepted.
    logic [7:0]  cur_debounce;
    logic [15:0] cur_short;
    logic [15:0] cur_long;
    logic [3:0]  cur_mask;

    // Our own copy of the per-button state.
    bcd_pkg::t_phase btn_phase[bcd_pkg::NUM_BUTTONS];
    logic [15:0]     btn_tick[bcd_pkg::NUM_BUTTONS];
    logic [7:0]      btn_deb[bcd_pkg::NUM_BUTTONS];
    logic            btn_level[bcd_pkg::NUM_BUTTONS];
    logic [3:0]      btn_reps[bcd_pkg::NUM_BUTTONS];
    bcd_pkg::t_event btn_last[bcd_pkg::NUM_BUTTONS];

    // Gesture planner state: each button plays runs of a constant pin level.
    int          run_left[bcd_pkg::NUM_BUTTONS];
    bit          run_lvl[bcd_pkg::NUM_BUTTONS];
    int          presses_left[bcd_pkg::NUM_BUTTONS];
    bit          holding[bcd_pkg::NUM_BUTTONS];

    button_click_detector uut (
        .i_clk              (clk),
        .i_rst_n            (rst_n),
        .i_in_valid         (in_valid),
        .o_in_ready         (o_in_ready),
        .i_button_index     (button_index),
        .i_pin_sample       (pin_sample),
        .o_out_valid        (o_out_valid),
        .i_out_ready        (out_ready),
        .o_button_index_out (o_button_index_out),
        .o_event_code       (o_event_code),
        .o_fired_mask       (o_fired_mask),
        .o_repeat_count     (o_repeat_count),
        .o_debounced_level  (o_debounced_level),
        .i_cfg_valid        (cfg_valid),
        .o_cfg_ready        (o_cfg_ready),
        .i_cfg_index        (cfg_index),
        .i_cfg_data         (cfg_data)
    );

    initial begin
        forever #2 clk = ~clk;
    end

    // Advances one button by one tick sample and returns the report it gives:
    // debounce first, then the press machine on the filtered level.
    function automatic t_click_report detect_tick(input logic [1:0] b, input logic pin);
        logic          act;
        logic          pressed;
        logic [15:0]   t;
        t_click_report r;
        act = cur_mask[b];
        r.fired = '0;
        if (btn_phase[b] != bcd_pkg::PH_IDLE && btn_tick[b] != bcd_pkg::TICK_MAX)
            btn_tick[b] = btn_tick[b] + 16'd1;
        if (pin != btn_level[b]) begin
            if (btn_deb[b] != bcd_pkg::DEB_MAX)
                btn_deb[b] = btn_deb[b] + 8'd1;
            if (btn_deb[b] >= cur_debounce) begin
                btn_level[b] = pin;
                btn_deb[b] = '0;
            end
        end else begin
            btn_deb[b] = '0;
        end
        pressed = (btn_level[b] == act);
        t = btn_tick[b];
        case (btn_phase[b])
            bcd_pkg::PH_IDLE: begin
                if (pressed) begin
                    btn_last[b] = bcd_pkg::EV_DOWN;
                    r.fired[bcd_pkg::F_DOWN] = 1'b1;
                    btn_tick[b] = '0;
                    btn_reps[b] = 4'd1;
                    btn_phase[b] = bcd_pkg::PH_PRESSED;
                end else begin
                    btn_last[b] = bcd_pkg::EV_NONE;
                end
            end
            bcd_pkg::PH_PRESSED: begin
                if (!pressed) begin
                    btn_last[b] = bcd_pkg::EV_UP;
                    r.fired[bcd_pkg::F_UP] = 1'b1;
                    btn_tick[b] = '0;
                    btn_phase[b] = bcd_pkg::PH_RELEASED;
                end else if (t > cur_long) begin
                    btn_last[b] = bcd_pkg::EV_LSTART;
                    r.fired[bcd_pkg::F_LSTART] = 1'b1;
                    btn_phase[b] = bcd_pkg::PH_LONG_HOLD;
                end
            end
            bcd_pkg::PH_RELEASED: begin
                if (pressed) begin
                    btn_last[b] = bcd_pkg::EV_DOWN;
                    r.fired[bcd_pkg::F_DOWN] = 1'b1;
                    r.fired[bcd_pkg::F_REPEAT] = 1'b1;
                    if (btn_reps[b] < bcd_pkg::REPEAT_MAX)
                        btn_reps[b] = btn_reps[b] + 4'd1;
                    btn_tick[b] = '0;
                    btn_phase[b] = bcd_pkg::PH_REPEAT;
                end else if (t > cur_short) begin
                    if (btn_reps[b] == 4'd1) begin
                        btn_last[b] = bcd_pkg::EV_SINGLE;
                        r.fired[bcd_pkg::F_SINGLE] = 1'b1;
                    end else if (btn_reps[b] == 4'd2) begin
                        btn_last[b] = bcd_pkg::EV_DOUBLE;
                        r.fired[bcd_pkg::F_DOUBLE] = 1'b1;
                    end
                    btn_phase[b] = bcd_pkg::PH_IDLE;
                end
            end
            bcd_pkg::PH_REPEAT: begin
                if (!pressed) begin
                    btn_last[b] = bcd_pkg::EV_UP;
                    r.fired[bcd_pkg::F_UP] = 1'b1;
                    if (t < cur_short) begin
                        btn_tick[b] = '0;
                        btn_phase[b] = bcd_pkg::PH_RELEASED;
                    end else begin
                        btn_phase[b] = bcd_pkg::PH_IDLE;
                    end
                end else if (t > cur_short) begin
                    btn_phase[b] = bcd_pkg::PH_IDLE;
                end
            end
            bcd_pkg::PH_LONG_HOLD: begin
                if (pressed) begin
                    btn_last[b] = bcd_pkg::EV_LHOLD;
                    r.fired[bcd_pkg::F_LHOLD] = 1'b1;
                end else begin
                    btn_last[b] = bcd_pkg::EV_UP;
                    r.fired[bcd_pkg::F_UP] = 1'b1;
                    btn_phase[b] = bcd_pkg::PH_IDLE;
                end
            end
            default: btn_phase[b] = bcd_pkg::PH_IDLE;
        endcase
        r.button = b;
        r.evt = btn_last[b];
        r.repeats = btn_reps[b];
        r.level = btn_level[b];
        return r;
    endfunction

    // Keeps the predictor in step with reset and with accepted register writes.
    // Writes only happen while no item is in flight, so this never races with
    // a prediction.
    always @(posedge clk) begin
        if (!rst_n) begin
            cur_debounce = 8'd3;
            cur_short = 16'd60;
            cur_long = 16'd200;
            cur_mask = 4'd0;
            for (int i = 0; i < bcd_pkg::NUM_BUTTONS; i++) begin
                btn_phase[i] = bcd_pkg::PH_IDLE;
                btn_tick[i] = '0;
                btn_deb[i] = '0;
                btn_level[i] = ~cur_mask[i];
                btn_reps[i] = '0;
                btn_last[i] = bcd_pkg::EV_NONE;
            end
        end else if (cfg_valid && o_cfg_ready) begin
            case (cfg_index)
                bcd_pkg::CFG_DEBOUNCE: cur_debounce = cfg_data[7:0];
                bcd_pkg::CFG_SHORT:    cur_short = cfg_data;
                bcd_pkg::CFG_LONG:     cur_long = cfg_data;
                bcd_pkg::CFG_ACTIVE:   cur_mask = cfg_data[3:0];
                default:               ;
            endcase
        end
    end

    // Input driver. When an item is accepted its report is predicted at once.
    // A new item is only loaded when the channel is empty or its item is being
    // taken at this edge, so valid and the payload hold steady while waiting.
    always @(posedge clk) begin : drive_ticks
        t_tick_item nxt;
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && o_in_ready)
                click_report_q.push_back(detect_tick(button_index, pin_sample));
            if (!in_valid || o_in_ready) begin
                if (tick_items_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    nxt = tick_items_q.pop_front();
                    in_valid <= 1'b1;
                    button_index <= nxt.button;
                    pin_sample <= nxt.pin;
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    function automatic void check_field(input string name, input logic [15:0] want,
                                        input logic [15:0] got);
        if (got !== want) begin
            $display("%0t ns: MISMATCH %s expected %0d actual %0d", $time, name, want, got);
            failed = 1'b1;
        end
    endfunction

    // Result monitor. Every accepted result is held against the oldest
    // prediction; ready is redrawn every cycle to stall the block at random.
    always @(posedge clk) begin : check_reports
        t_click_report want;
        if (!rst_n) begin
            out_ready <= 1'b0;
        end else begin
            if (o_out_valid && out_ready) begin
                if (click_report_q.size() == 0) begin
                    $display("%0t ns: MISMATCH unexpected result item for button %0d",
                             $time, o_button_index_out);
                    failed = 1'b1;
                end else begin
                    want = click_report_q.pop_front();
                    check_field("button_index_out", 16'(want.button), 16'(o_button_index_out));
                    check_field("event_code", 16'(want.evt), 16'(o_event_code));
                    check_field("fired_mask", 16'(want.fired), 16'(o_fired_mask));
                    check_field("repeat_count", 16'(want.repeats), 16'(o_repeat_count));
                    check_field("debounced_level", 16'(want.level), 16'(o_debounced_level));
                end
            end
            out_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Queues n samples of one button at one pin level.
    task automatic push_run(input logic [1:0] b, input logic pin, input int n);
        t_tick_item it;
        it.button = b;
        it.pin = pin;
        repeat (n) tick_items_q.push_back(it);
    endtask

    // Waits until every queued item has been taken and every report has come
    // back, and then lets the block settle so that it is surely quiet.
    task automatic drain_pipeline();
        while (tick_items_q.size() != 0 || in_valid || click_report_q.size() != 0)
            @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    task automatic write_reg(input bcd_pkg::t_cfg_idx idx, input logic [15:0] data);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do @(posedge clk); while (!o_cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    // Writes all four registers. The unused upper bits of the narrow registers
    // carry random junk, which the block has to drop.
    task automatic set_config(input logic [7:0] deb, input logic [15:0] short_lim,
                              input logic [15:0] long_lim, input logic [3:0] mask);
        write_reg(bcd_pkg::CFG_DEBOUNCE, {8'($urandom), deb});
        write_reg(bcd_pkg::CFG_SHORT, short_lim);
        write_reg(bcd_pkg::CFG_LONG, long_lim);
        write_reg(bcd_pkg::CFG_ACTIVE, {12'($urandom), mask});
        repeat (2) @(posedge clk);
    endtask

    // Picks the next run of constant pin level for one button. Most runs come
    // from well-formed gestures (click sequences and long presses) whose run
    // lengths straddle the debounce, click and hold limits; the rest are
    // glitches of random level. Huge limits are capped so runs stay short.
    task automatic plan_next_run(input logic [1:0] b);
        int   d;
        int   sc;
        int   lc;
        int   press_len;
        int   pick;
        logic act;
        d = cur_debounce;
        sc = (cur_short > 16'd40) ? 40 : int'(cur_short);
        lc = (cur_long > 16'd300) ? 300 : int'(cur_long);
        act = cur_mask[b];
        press_len = d + $urandom_range(1, sc + 2);
        if (holding[b]) begin
            // A press just ended: either a short gap before the next press of
            // the sequence, or a gap long enough to let the sequence time out.
            holding[b] = 1'b0;
            run_lvl[b] = ~act;
            if (presses_left[b] > 0)
                run_left[b] = d + $urandom_range(1, sc);
            else
                run_left[b] = d + sc + $urandom_range(2, 6);
        end else if (presses_left[b] > 0) begin
            presses_left[b]--;
            holding[b] = 1'b1;
            run_lvl[b] = act;
            run_left[b] = press_len;
        end else begin
            pick = $urandom_range(99);
            if (pick < 65) begin
                pick = $urandom_range(99);
                if (pick < 50)
                    presses_left[b] = 0;
                else if (pick < 75)
                    presses_left[b] = 1;
                else if (pick < 90)
                    presses_left[b] = $urandom_range(2, 4);
                else
                    presses_left[b] = $urandom_range(5, 16);
                holding[b] = 1'b1;
                run_lvl[b] = act;
                run_left[b] = press_len;
            end else if (pick < 80) begin
                presses_left[b] = 0;
                holding[b] = 1'b1;
                run_lvl[b] = act;
                run_left[b] = d + lc + $urandom_range(1, 8);
            end else begin
                run_lvl[b] = $urandom_range(1);
                run_left[b] = $urandom_range(1, d + 1);
            end
        end
    endtask

    // Interleaves the buttons' gestures. Half the time the button is redrawn,
    // else it comes again, so back-to-back items on one button are frequent.
    task automatic queue_gestures(input int n);
        logic [1:0] b;
        b = 2'($urandom);
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(1) == 0)
                b = 2'($urandom);
            if (run_left[b] <= 0)
                plan_next_run(b);
            push_run(b, run_lvl[b], 1);
            run_left[b]--;
        end
    endtask

    task automatic run_random(input int unsigned send_pct, input int unsigned recv_pct,
                              input int n);
        send_idle_pct = send_pct;
        recv_stall_pct = recv_pct;
        for (int i = 0; i < bcd_pkg::NUM_BUTTONS; i++) begin
            run_left[i] = 0;
            presses_left[i] = 0;
            holding[i] = 1'b0;
        end
        queue_gestures(n);
        drain_pipeline();
    endtask

    initial begin : main_sequence
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // Directed items under the reset settings (debounce of three, pressed
        // level low): a press and release on button 0, a glitch shorter than
        // the debounce on button 2, a quick second press on button 3 that
        // counts as a repeat, idle samples and one active sample on button 1.
        push_run(2'd0, 1'b0, 3);
        push_run(2'd1, 1'b1, 1);
        push_run(2'd0, 1'b1, 3);
        push_run(2'd2, 1'b0, 2);
        push_run(2'd2, 1'b1, 1);
        push_run(2'd3, 1'b0, 3);
        push_run(2'd3, 1'b1, 3);
        push_run(2'd3, 1'b0, 3);
        push_run(2'd3, 1'b1, 3);
        push_run(2'd1, 1'b0, 1);
        push_run(2'd2, 1'b1, 1);
        drain_pipeline();

        // Random gestures, first with the reset settings and no idling.
        run_random(0, 0, 200);
        // All buttons active high, short limits, sender gaps.
        set_config(8'd1, 16'd8, 16'd12, 4'hF);
        run_random(49, 0, 200);
        set_config(8'd2, 16'd5, 16'd6, 4'($urandom));
        run_random(0, 49, 200);
        // A debounce of zero follows the pin at once; both limits are one.
        set_config(8'd0, 16'd1, 16'd1, 4'h5);
        run_random(24, 24, 150);
        // The largest click limit: sequences never time out, so the press
        // count climbs until it saturates.
        set_config(8'd1, 16'hFFFF, 16'd20, 4'hA);
        run_random(0, 0, 200);
        // The largest debounce: every level change takes 255 samples.
        set_config(8'hFF, 16'd300, 16'd600, 4'h3);
        run_random(49, 0, 300);

        // The largest hold limit: button 2 is released long enough to return
        // to idle, then held down well past every other limit without a long
        // press starting. Then it is let go.
        set_config(8'd1, 16'd10, 16'hFFFF, 4'h0);
        send_idle_pct = 0;
        recv_stall_pct = 0;
        push_run(2'd2, 1'b1, 40);
        push_run(2'd2, 1'b0, 100);
        push_run(2'd2, 1'b1, 8);
        drain_pipeline();

        // A few more random settings, each with a different idling pattern.
        for (int i = 0; i < 3; i++) begin
            set_config(8'($urandom_range(1, 6)), 16'($urandom_range(2, 30)),
                       16'($urandom_range(2, 60)), 4'($urandom));
            case (i)
                0:       run_random(24, 24, 60);
                1:       run_random(49, 0, 60);
                default: run_random(0, 49, 60);
            endcase
        end

        repeat (10) @(posedge clk);
        if (!failed) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    // Watchdog: the slowest correct run needs well under a tenth of this.
    initial begin : watchdog
        #4ms;
        $display("Test completed with failures");
        $finish;
    end

endmodule

FILE: filelist.f
rtl/core/bcd_pkg.sv
rtl/core/bcd_cfg_regs.sv
rtl/core/bcd_state_mem.sv
rtl/core/bcd_press_fsm.sv
rtl/core/button_click_detector.sv
rtl/core/bcd_checker.sv
test/tb_top.sv
